// ----- src/flux_limiter_factor_row_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Flux limiter row unit: shared assertion macros
// Implication checks clocked on the rising edge and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FLUX_LIMITER_FACTOR_ROW_UNIT_DEFINES_SVH
`define FLUX_LIMITER_FACTOR_ROW_UNIT_DEFINES_SVH

// same-cycle implication
`define FLR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/flr_pkg.sv -----
// ----------------------------------------------------------------------------
// Flux limiter row unit package
// Entry, row record and result types, back end states and fixed constants.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int unsigned SUM_W    = 40;
  localparam int unsigned NUM_W    = 63;
  localparam int unsigned FACTOR_W = 17;
  localparam int unsigned QUO_BITS = 16;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

  typedef struct packed {
    logic signed [31:0] u_row;
    logic        [30:0] mass_row;
    logic signed [31:0] u_neighbor;
    logic signed [31:0] flux;
    logic               on_diagonal;
    logic               row_last;
  } flr_in_t;

  typedef struct packed {
    logic signed [32:0]         lower_bound;
    logic        [31:0]         upper_bound;
    logic        [FACTOR_W-1:0] factor_negative;
    logic        [FACTOR_W-1:0] factor_positive;
  } flr_out_t;

  // one finished row, handed from the front to the back
  typedef struct packed {
    logic signed [32:0]      lower_bound;
    logic        [31:0]      upper_bound;
    logic        [30:0]      mass;
    logic signed [SUM_W-1:0] neg_sum;
    logic        [SUM_W-1:0] pos_sum;
  } flr_row_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_CHECK,
    BK_DIV,
    BK_SEND
  } flr_back_state_t;

endpackage

// ----- src/flr_front.sv -----
// ----------------------------------------------------------------------------
// Flux limiter front end
// Folds each entry into the row's min/max and saturating flux sums and
// emits one row record at the last entry.
// ----------------------------------------------------------------------------
module flr_front
  import flr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  flr_in_t  entry,
  output logic     row_push,
  output flr_row_t row_rec
);

  logic signed [31:0]      min_value, min_value_next;
  logic signed [31:0]      max_value, max_value_next;
  logic signed [SUM_W-1:0] neg_sum, neg_sum_next;
  logic        [SUM_W-1:0] pos_sum, pos_sum_next;
  logic                    row_open;

  logic signed [31:0]      min_base, max_base, min_mid, max_mid;
  logic signed [SUM_W-1:0] neg_base;
  logic        [SUM_W-1:0] pos_base;
  logic signed [SUM_W:0]   neg_add;
  logic        [SUM_W:0]   pos_add;
  logic signed [32:0]      qn_full, qp_full;

  always_comb begin
    min_base = row_open ? min_value : entry.u_row;
    max_base = row_open ? max_value : entry.u_row;
    neg_base = row_open ? neg_sum : '0;
    pos_base = row_open ? pos_sum : '0;

    min_mid        = (entry.u_row < min_base) ? entry.u_row : min_base;
    max_mid        = (entry.u_row > max_base) ? entry.u_row : max_base;
    min_value_next = (entry.u_neighbor < min_mid) ? entry.u_neighbor : min_mid;
    max_value_next = (entry.u_neighbor > max_mid) ? entry.u_neighbor : max_mid;

    neg_add = {neg_base[SUM_W-1], neg_base} + (SUM_W+1)'(entry.flux);
    pos_add = {1'b0, pos_base} + {{(SUM_W-30){1'b0}}, entry.flux[30:0]};

    neg_sum_next = neg_base;
    pos_sum_next = pos_base;
    if (!entry.on_diagonal) begin
      if (entry.flux[31]) begin
        // clamp at -2^39
        if (neg_add[SUM_W:SUM_W-1] == 2'b10) begin
          neg_sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
          neg_sum_next = neg_add[SUM_W-1:0];
        end
      end else begin
        pos_sum_next = pos_add[SUM_W] ? {SUM_W{1'b1}} : pos_add[SUM_W-1:0];
      end
    end

    qn_full = 33'(min_value_next) - 33'(entry.u_row);
    qp_full = 33'(max_value_next) - 33'(entry.u_row);

    row_rec.lower_bound = qn_full;
    row_rec.upper_bound = qp_full[31:0];
    row_rec.mass        = entry.mass_row;
    row_rec.neg_sum     = neg_sum_next;
    row_rec.pos_sum     = pos_sum_next;
    row_push            = accept && entry.row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_open <= 1'b0;
    end else if (accept) begin
      row_open <= !entry.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_value <= min_value_next;
      max_value <= max_value_next;
      neg_sum   <= neg_sum_next;
      pos_sum   <= pos_sum_next;
    end
  end

endmodule

// ----- src/flr_row_queue.sv -----
// ----------------------------------------------------------------------------
// Flux limiter row queue
// Small circular queue of finished row records between front and back.
// ----------------------------------------------------------------------------
module flr_row_queue
  import flr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  flr_row_t wr_data,
  output logic     full,
  input  logic     rd,
  output flr_row_t rd_data,
  output logic     empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  flr_row_t           slots [DEPTH];
  logic [PTR_W-1:0]   head, tail;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_rd) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[tail] <= wr_data;
    end
  end

endmodule

// ----- src/flr_back.sv -----
// ----------------------------------------------------------------------------
// Flux limiter back end
// Per row: bound times mass, then two restoring dividers (one quotient bit
// per cycle) for the negative and positive factors, then the result register.
// ----------------------------------------------------------------------------
`include "flux_limiter_factor_row_unit_defines.svh"

module flr_back
  import flr_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     row_valid,
  input  flr_row_t row_rec,
  output logic     row_pop,
  input  logic     pop,
  output logic     empty,
  output flr_out_t result
);

  localparam int unsigned D_W = SUM_W + FRACTION_BITS;
  localparam int unsigned R_W = (D_W > NUM_W) ? D_W : NUM_W;
  localparam int unsigned C_W = $clog2(QUO_BITS);

  flr_back_state_t state, state_next;

  logic signed [32:0]  qn_hold;
  logic [31:0]         qp_hold;
  logic [31:0]         neg_mag;
  logic [30:0]         mass;
  logic [SUM_W-1:0]    den_n, den_p;
  logic                en_n, en_p;
  logic [NUM_W-1:0]    num_n, num_p;
  logic [R_W-1:0]      rem_n, rem_p, rem_n_next, rem_p_next;
  logic [R_W-1:0]      d_n, d_p;
  logic [FACTOR_W-1:0] quo_n, quo_p, quo_n_next, quo_p_next;
  logic                fixed_n, fixed_p;
  logic [C_W-1:0]      count;
  logic                out_valid;
  logic                load_out;

  // one restoring step; rem stays below d so the shifted value fits in R_W+1
  function automatic logic [R_W:0] div_step(input logic [R_W-1:0] rem,
                                            input logic [R_W-1:0] d);
    logic [R_W:0] sh;
    logic [R_W:0] diff;
    sh   = {rem, 1'b0};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      div_step = {1'b1, diff[R_W-1:0]};
    end else begin
      div_step = {1'b0, sh[R_W-1:0]};
    end
  endfunction

  assign d_n = R_W'(den_n) << FRACTION_BITS;
  assign d_p = R_W'(den_p) << FRACTION_BITS;

  always_comb begin
    logic [R_W:0] step_n;
    logic [R_W:0] step_p;
    step_n     = div_step(rem_n, d_n);
    step_p     = div_step(rem_p, d_p);
    rem_n_next = step_n[R_W-1:0];
    rem_p_next = step_p[R_W-1:0];
    quo_n_next = {quo_n[FACTOR_W-2:0], step_n[R_W]};
    quo_p_next = {quo_p[FACTOR_W-2:0], step_p[R_W]};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (row_valid) state_next = BK_MULT;
      BK_MULT:  state_next = BK_CHECK;
      BK_CHECK: state_next = BK_DIV;
      BK_DIV:   if (count == C_W'(QUO_BITS - 1)) state_next = BK_SEND;
      BK_SEND:  if (!out_valid || pop) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    row_pop  = (state == BK_IDLE) && row_valid;
    load_out = (state == BK_SEND) && (!out_valid || pop);
    empty    = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (state == BK_DIV) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (row_valid) begin
          qn_hold <= row_rec.lower_bound;
          qp_hold <= row_rec.upper_bound;
          neg_mag <= 32'(-row_rec.lower_bound);
          mass    <= row_rec.mass;
          en_n    <= row_rec.neg_sum[SUM_W-1];
          en_p    <= (row_rec.pos_sum != '0);
          den_n   <= SUM_W'(-row_rec.neg_sum);
          den_p   <= row_rec.pos_sum;
        end
      end
      BK_MULT: begin
        num_n <= NUM_W'(neg_mag * mass);
        num_p <= NUM_W'(qp_hold * mass);
      end
      BK_CHECK: begin
        rem_n <= R_W'(num_n);
        rem_p <= R_W'(num_p);
        if (!en_n || num_n == '0) begin
          fixed_n <= 1'b1;
          quo_n   <= '0;
        end else if (R_W'(num_n) >= d_n) begin
          fixed_n <= 1'b1;
          quo_n   <= FACTOR_ONE;
        end else begin
          fixed_n <= 1'b0;
          quo_n   <= '0;
        end
        if (!en_p || num_p == '0) begin
          fixed_p <= 1'b1;
          quo_p   <= '0;
        end else if (R_W'(num_p) >= d_p) begin
          fixed_p <= 1'b1;
          quo_p   <= FACTOR_ONE;
        end else begin
          fixed_p <= 1'b0;
          quo_p   <= '0;
        end
      end
      BK_DIV: begin
        if (!fixed_n) begin
          rem_n <= rem_n_next;
          quo_n <= quo_n_next;
        end
        if (!fixed_p) begin
          rem_p <= rem_p_next;
          quo_p <= quo_p_next;
        end
      end
      BK_SEND: begin
        if (load_out) begin
          result.lower_bound     <= qn_hold;
          result.upper_bound     <= qp_hold;
          result.factor_negative <= quo_n;
          result.factor_positive <= quo_p;
        end
      end
      default: begin
      end
    endcase
  end

  `FLR_ASSERT_NEXT(a_row_starts, clk, rst, (state == BK_IDLE) && row_valid, state == BK_MULT, "row taken but no multiply step")
  `FLR_ASSERT_IMPL(a_rem_n_below, clk, rst, (state == BK_DIV) && !fixed_n, rem_n < d_n, "negative remainder not below divisor")
  `FLR_ASSERT_IMPL(a_rem_p_below, clk, rst, (state == BK_DIV) && !fixed_p, rem_p < d_p, "positive remainder not below divisor")
  `FLR_ASSERT_IMPL(a_factor_range, clk, rst, out_valid, (result.factor_negative <= FACTOR_ONE) && (result.factor_positive <= FACTOR_ONE), "factor above one")

endmodule

// ----- src/flux_limiter_factor_row_unit.sv -----
// Flux limiter row unit: takes one matrix entry per cycle, full only when the row queue is full.
// Result path after the last entry of a row with the back end idle: queue pop, multiply,
// check, 16 divide steps, result load.
// Back end: takes one row at a time, a new one only after the bit-serial dividers and result
// load of the last; the row queue absorbs short rows.
// Reset (rst, synchronous): clears the open row, the row queue and the result valid flag.
// ----------------------------------------------------------------------------
// Flux limiter factor row unit
// Front folds row entries into bounds and flux sums, queue holds finished
// rows, back computes the bounded limiter factors.
// ----------------------------------------------------------------------------
module flux_limiter_factor_row_unit
  import flr_pkg::*;
#(
  parameter int unsigned FRACTION_BITS   = 16,
  parameter int unsigned ROW_QUEUE_DEPTH = 4
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  flr_in_t  item,
  output logic     empty,
  input  logic     pop,
  output flr_out_t result
);

  logic     accept;
  logic     row_push;
  flr_row_t row_in, row_out;
  logic     row_empty;
  logic     row_pop;

  assign accept = push && !full;

  flr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .entry    (item),
    .row_push (row_push),
    .row_rec  (row_in)
  );

  flr_row_queue #(
    .DEPTH (ROW_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (row_push),
    .wr_data (row_in),
    .full    (full),
    .rd      (row_pop),
    .rd_data (row_out),
    .empty   (row_empty)
  );

  flr_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .row_valid (!row_empty),
    .row_rec   (row_out),
    .row_pop   (row_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ----- tb/sv/tb_flux_limiter_factor_row_unit.sv -----
// ----------------------------------------------------------------------------
// Flux limiter factor row unit testbench
// Streams sparse matrix rows through the unit and checks every row result
// (bounds and limiter factors) against an in-bench row predictor. Directed
// corners first, then flux sum saturation, a long output hold-off that fills
// the row queue, and random rows under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_flux_limiter_factor_row_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import flr_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] MASS_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam longint NEG_SUM_FLOOR = -(64'sd1 <<< 39);
  localparam longint unsigned POS_SUM_CEIL = (64'd1 << 40) - 64'd1;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  flr_in_t item = '0;
  logic empty;
  logic pop = 1'b0;
  flr_out_t result;

  flux_limiter_factor_row_unit #(
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always #6 clk = ~clk;

  // row predictor state
  longint flux_neg_sum = 0;
  longint unsigned flux_pos_sum = 0;
  int row_min = 0;
  int row_max = 0;
  bit row_in_progress = 1'b0;
  flr_out_t row_results_due[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  flr_out_t due;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // floor(num * 2^16 / (den * 2^FRAC)), saturating at one
  function automatic logic [FACTOR_W-1:0] limiter_factor(input longint unsigned num,
                                                         input longint unsigned den);
    logic [79:0] scaled_den;
    logic [79:0] quotient;
    if (num == 0 || den == 0) return '0;
    scaled_den = 80'(den) << FRAC;
    if (80'(num) >= scaled_den) return FACTOR_ONE;
    quotient = {num, 16'h0} / scaled_den;
    return quotient[FACTOR_W-1:0];
  endfunction

  task automatic fold_entry(input flr_in_t e);
    int ur;
    int un;
    int fl;
    longint qn;
    longint qp;
    longint unsigned mass;
    flr_out_t r;
    ur = e.u_row;
    un = e.u_neighbor;
    fl = e.flux;
    mass = e.mass_row;
    if (!row_in_progress) begin
      row_min = ur;
      row_max = ur;
      flux_neg_sum = 0;
      flux_pos_sum = 0;
      row_in_progress = 1'b1;
    end
    if (ur < row_min) row_min = ur;
    if (ur > row_max) row_max = ur;
    if (un < row_min) row_min = un;
    if (un > row_max) row_max = un;
    if (!e.on_diagonal) begin
      if (fl <= 0) begin
        flux_neg_sum += fl;
        if (flux_neg_sum < NEG_SUM_FLOOR) flux_neg_sum = NEG_SUM_FLOOR;
      end else begin
        flux_pos_sum += fl;
        if (flux_pos_sum > POS_SUM_CEIL) flux_pos_sum = POS_SUM_CEIL;
      end
    end
    if (e.row_last) begin
      // bounds use the row value of the closing entry
      qn = longint'(row_min) - longint'(ur);
      qp = longint'(row_max) - longint'(ur);
      r.lower_bound = qn[32:0];
      r.upper_bound = qp[31:0];
      r.factor_negative = (flux_neg_sum < 0) ?
                          limiter_factor(-qn * mass, -flux_neg_sum) : '0;
      r.factor_positive = (flux_pos_sum > 0) ?
                          limiter_factor(qp * mass, flux_pos_sum) : '0;
      row_results_due.push_back(r);
      row_in_progress = 1'b0;
    end
  endtask

  // result side: random stalls, plus a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (row_results_due.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", result));
      end else begin
        due = row_results_due.pop_front();
        if (result.lower_bound !== due.lower_bound)
          report_mismatch($sformatf("lower_bound got %0d want %0d",
                                    result.lower_bound, due.lower_bound));
        if (result.upper_bound !== due.upper_bound)
          report_mismatch($sformatf("upper_bound got %0d want %0d",
                                    result.upper_bound, due.upper_bound));
        if (result.factor_negative !== due.factor_negative)
          report_mismatch($sformatf("factor_negative got %0d want %0d",
                                    result.factor_negative, due.factor_negative));
        if (result.factor_positive !== due.factor_positive)
          report_mismatch($sformatf("factor_positive got %0d want %0d",
                                    result.factor_positive, due.factor_positive));
      end
    end
  end

  // called at a falling edge, returns at a falling edge with push still high
  task automatic send_entry(input flr_in_t e);
    int gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    fold_entry(e);
    @(negedge clk);
  endtask

  task automatic wait_results();
    push <= 1'b0;
    @(negedge clk);
    while (row_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int pop_pct);
    send_idle_pct = send_pct;
    stall_pct <= pop_pct;
  endtask

  function automatic flr_in_t make_entry(input logic signed [31:0] ur,
                                         input logic [30:0] m,
                                         input logic signed [31:0] un,
                                         input logic signed [31:0] fl,
                                         input logic diag, input logic last);
    flr_in_t e;
    e.u_row = ur;
    e.mass_row = m;
    e.u_neighbor = un;
    e.flux = fl;
    e.on_diagonal = diag;
    e.row_last = last;
    return e;
  endfunction

  // scale 0: full range, 1-3: around one, 4: tiny, 5: corner values
  function automatic logic signed [31:0] pick_value(input int sc);
    logic signed [31:0] v;
    case (sc)
      0: v = $urandom;
      1, 2, 3: v = $urandom_range(1 << 18);
      4: v = $urandom_range(255);
      default: begin
        case ($urandom_range(3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = $urandom;
        endcase
      end
    endcase
    if (sc >= 1 && sc <= 4 && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [30:0] pick_mass(input int sc);
    logic [30:0] m;
    case (sc)
      0: m = 31'($urandom);
      1, 2, 3: m = 31'($urandom_range(1 << 18));
      4: m = 31'($urandom_range(255));
      default: begin
        case ($urandom_range(2))
          0: m = '0;
          1: m = MASS_MAX;
          default: m = 31'(Q_ONE);
        endcase
      end
    endcase
    return m;
  endfunction

  task automatic send_random_rows(input int n_items, input int max_len);
    flr_in_t e;
    int sent;
    int len;
    int k;
    int vsc;
    int msc;
    int fsc;
    sent = 0;
    while (sent < n_items) begin
      if (max_len > 1 && $urandom_range(9) == 0)
        len = $urandom_range(4 * max_len, max_len + 1);
      else
        len = $urandom_range(max_len, 1);
      vsc = $urandom_range(5);
      msc = $urandom_range(5);
      fsc = $urandom_range(5);
      e.u_row = pick_value(vsc);
      e.mass_row = pick_mass(msc);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(15) == 0) e.u_row = pick_value(vsc);
        if ($urandom_range(15) == 0) e.mass_row = pick_mass(msc);
        e.u_neighbor = pick_value(vsc);
        e.flux = pick_value(fsc);
        e.on_diagonal = ($urandom_range(5) == 0);
        e.row_last = (k == len - 1);
        send_entry(e);
        sent++;
      end
    end
  endtask

  task automatic test_value_extremes();
    set_idling(0, 0);
    send_entry(make_entry(VAL_MIN, MASS_MAX, VAL_MAX, VAL_MIN, 1'b0, 1'b1));
    send_entry(make_entry(VAL_MAX, MASS_MAX, VAL_MIN, VAL_MAX, 1'b0, 1'b1));
    send_entry(make_entry(VAL_MAX, MASS_MAX, VAL_MIN, VAL_MIN, 1'b0, 1'b0));
    send_entry(make_entry(VAL_MAX, MASS_MAX, VAL_MAX, VAL_MAX, 1'b0, 1'b1));
  endtask

  task automatic test_factor_rounding();
    // exactly one
    send_entry(make_entry('0, 31'(Q_ONE), -Q_ONE, -Q_ONE, 1'b0, 1'b1));
    // truncated fractions on both sides
    send_entry(make_entry('0, 31'(Q_ONE), -(Q_ONE / 2), -3 * Q_ONE, 1'b0, 1'b0));
    send_entry(make_entry('0, 31'(Q_ONE), Q_ONE / 2, 3 * Q_ONE, 1'b0, 1'b1));
    // just under one
    send_entry(make_entry('0, 31'(Q_ONE), -Q_ONE, -(Q_ONE + 1), 1'b0, 1'b0));
    send_entry(make_entry('0, 31'(Q_ONE), Q_ONE, Q_ONE + 1, 1'b0, 1'b1));
  endtask

  task automatic test_zero_cases();
    // zero mass
    send_entry(make_entry('0, '0, -Q_ONE, -Q_ONE, 1'b0, 1'b0));
    send_entry(make_entry('0, '0, Q_ONE, Q_ONE, 1'b0, 1'b1));
    // zero bounds
    send_entry(make_entry(32'sd5, 31'(Q_ONE), 32'sd5, -Q_ONE, 1'b0, 1'b0));
    send_entry(make_entry(32'sd5, 31'(Q_ONE), 32'sd5, Q_ONE, 1'b0, 1'b1));
    // diagonal only: no sums at all
    send_entry(make_entry('0, 31'(Q_ONE), -Q_ONE, -Q_ONE, 1'b1, 1'b1));
    // zero flux leaves both sums at zero (predictor: negative side, unit: positive side)
    send_entry(make_entry('0, 31'(Q_ONE), Q_ONE, '0, 1'b0, 1'b1));
  endtask

  task automatic test_row_value_change();
    send_entry(make_entry('0, 31'(Q_ONE), '0, -Q_ONE, 1'b0, 1'b0));
    send_entry(make_entry(3 * Q_ONE, 31'(2 * Q_ONE), Q_ONE, Q_ONE, 1'b1, 1'b0));
    send_entry(make_entry(-Q_ONE, 31'(Q_ONE / 2), Q_ONE / 4, 2 * Q_ONE, 1'b0, 1'b0));
    send_entry(make_entry(Q_ONE, 31'(3 * Q_ONE), '0, -(Q_ONE / 3), 1'b0, 1'b1));
  endtask

  // negative sum driven past its floor; mass chosen so that a saturated sum
  // and an unsaturated one differ in the factor
  task automatic test_sum_saturation();
    int k;
    set_idling(0, 0);
    for (k = 0; k < 258; k++)
      send_entry(make_entry('0, 31'h00FF_FFFF, VAL_MIN, VAL_MIN, 1'b0, 1'b0));
    send_entry(make_entry('0, 31'h00FF_FFFF, '0, VAL_MAX, 1'b1, 1'b0));
    send_entry(make_entry('0, 31'h00FF_FFFF, VAL_MAX, VAL_MAX, 1'b0, 1'b1));
  endtask

  // result side held off while single-entry rows keep coming: queue fills
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_left <= HOLD_CYCLES;
    send_random_rows(30, 1);
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    send_random_rows(PHASE_ITEMS, 8);
    set_idling(45, 0);
    send_random_rows(PHASE_ITEMS, 8);
    set_idling(0, 45);
    send_random_rows(PHASE_ITEMS, 8);
    set_idling(8, 8);
    send_random_rows(PHASE_ITEMS, 8);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_value_extremes();
    test_factor_rounding();
    test_zero_cases();
    test_row_value_change();
    wait_results();
    test_sum_saturation();
    wait_results();
    test_backpressure();
    wait_results();
    test_random_traffic();
    wait_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d row results outstanding", row_results_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule
